// ----- src/lgcb_pkg.sv -----
// Shared types, constants and functions for the luma gated cross blend filter.
package lgcb_pkg;

  localparam int PIX_W          = 32;
  localparam int CH_W           = 8;
  localparam int NUM_CH         = 3;
  localparam int OUT_COL_W      = 10;
  localparam int OUT_ROW_W      = 12;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int FW_W           = 11;
  localparam int FH_W           = 13;
  localparam int FW_RESET       = 1024;
  localparam int FH_RESET       = 768;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Luma scaled by 1000: 299 R + 587 G + 114 B, at most 255000.
  localparam int LUMA_W         = 18;
  localparam int LUMA_R         = 299;
  localparam int LUMA_G         = 587;
  localparam int LUMA_B         = 114;
  localparam logic [LUMA_W-1:0] LUMA_THRESH = LUMA_W'(12000);

  // Cross tap count: centre, north, south, west, east.
  localparam int NUM_TAPS       = 5;

  // Weighted channel sum 2C+N+S+W+E, at most 1530.
  localparam int SUM_W          = 11;
  // Divide by six: (sum * 10923) >> 16 is exact for sums up to 1530.
  localparam int RECIP6_W       = 14;
  localparam int RECIP6         = 10923;
  localparam int RECIP_SHIFT    = 16;
  localparam int PROD_W         = SUM_W + RECIP6_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AA_ENABLE,
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT
  } cfg_idx_e;

  // Per-pixel control that rides along the filter pipeline.
  typedef struct packed {
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic                 sel;
    logic                 has_up;
    logic                 interior;
    logic                 emit_own;
    logic                 frame_end;
  } pix_ctl_t;

  function automatic logic [LUMA_W-1:0] luma1000(input logic [PIX_W-1:0] p);
    luma1000 = LUMA_W'(p[7:0])   * LUMA_W'(LUMA_R)
             + LUMA_W'(p[15:8])  * LUMA_W'(LUMA_G)
             + LUMA_W'(p[23:16]) * LUMA_W'(LUMA_B);
  endfunction

endpackage

// ----- src/lgcb_in_if.sv -----
// Input pixel channel: valid/ready handshake carrying one RGBA pixel per beat.
interface lgcb_in_if import lgcb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// ----- src/lgcb_out_if.sv -----
// Output pixel channel: valid/ready handshake carrying one result pixel per beat.
interface lgcb_out_if import lgcb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     pixel_out;
  logic [OUT_COL_W-1:0] out_column;
  logic [OUT_ROW_W-1:0] out_row;
  logic                 frame_end;

  modport source (output valid, output pixel_out, output out_column, output out_row,
                  output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input out_column, input out_row,
                  input frame_end, output ready);
endinterface

// ----- src/luma_gated_cross_blend_antialias.sv -----
// Top level of the luma gated cross blend anti-aliasing filter.
//
// Streaming edge filter for RGBA pixels (R in bits 7:0, alpha in 31:24) that arrive
// in raster order, one beat per pixel. Two line stores, each MAX_WIDTH x 32 bits with
// one write and two read ports, hold the original pixels of the two most recent rows;
// the incoming pixel overwrites the older row at its own column in the same cycle that
// the old word is read back as the north neighbour (read-first RAM). For each interior
// pixel the luma (299R+587G+114B) of the centre and its four cross neighbours is
// compared; if max minus min reaches 12000 the RGB channels become
// floor((2C+N+S+W+E)/6) and alpha is kept, otherwise the pixel passes. Borders, and
// every pixel when aa_enable is 0, pass unchanged. Output lags input by one row: a
// pixel in row r releases pixel (r-1, c); a last-row pixel also releases itself,
// with frame_end on the final pixel of the frame. First-row pixels release nothing,
// unless the frame is a single row. Throughput is one pixel per clock while the output
// accepts every beat; in the last row of a frame taller than one row the output channel
// carries two beats per input pixel, and the result sequencer sends both before it takes
// the next pixel, so input is held back there. The line stores are read at the edge that
// takes the releasing pixel; the luma and channel sums, the range and divide, the result
// sequencer and the output register then each register the result in that order.
// The line stores need no clearing after reset. Write configuration only while idle.
module luma_gated_cross_blend_antialias import lgcb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lgcb_in_if.sink               pix_in,
  lgcb_out_if.source            pix_out
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic             mem_re, mem_sel;
  logic [CW-1:0]    mem_col, mem_col_nxt;
  logic             s1_valid, s1_ready;
  pix_ctl_t         s1_ctl;
  logic [PIX_W-1:0] s1_pixel;
  logic [PIX_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
  logic             s3_valid, s3_ready;
  pix_ctl_t         s3_ctl;
  logic [PIX_W-1:0] s3_res, s3_pixel;

  lgcb_raster_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pix_in        (pix_in),
    .s1_ready_i    (s1_ready),
    .mem_re_o      (mem_re),
    .mem_sel_o     (mem_sel),
    .mem_col_o     (mem_col),
    .mem_col_nxt_o (mem_col_nxt),
    .s1_valid_o    (s1_valid),
    .s1_ctl_o      (s1_ctl),
    .s1_pixel_o    (s1_pixel)
  );

  // Newest row sits in store B when the select is set; write the other store.
  lgcb_line_mem #(.DEPTH(MAX_WIDTH)) u_store_a (
    .clk_i    (clk_i),
    .we_i     (mem_re && mem_sel),
    .waddr_i  (mem_col),
    .wdata_i  (pix_in.pixel_in),
    .re_i     (mem_re),
    .raddr0_i (mem_col),
    .raddr1_i (mem_col_nxt),
    .rdata0_o (a_rd0),
    .rdata1_o (a_rd1)
  );

  lgcb_line_mem #(.DEPTH(MAX_WIDTH)) u_store_b (
    .clk_i    (clk_i),
    .we_i     (mem_re && !mem_sel),
    .waddr_i  (mem_col),
    .wdata_i  (pix_in.pixel_in),
    .re_i     (mem_re),
    .raddr0_i (mem_col),
    .raddr1_i (mem_col_nxt),
    .rdata0_o (b_rd0),
    .rdata1_o (b_rd1)
  );

  lgcb_cross_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_ctl_i   (s1_ctl),
    .s1_pixel_i (s1_pixel),
    .a_rd0_i    (a_rd0),
    .a_rd1_i    (a_rd1),
    .b_rd0_i    (b_rd0),
    .b_rd1_i    (b_rd1),
    .s1_ready_o (s1_ready),
    .s3_valid_o (s3_valid),
    .s3_ctl_o   (s3_ctl),
    .s3_res_o   (s3_res),
    .s3_pixel_o (s3_pixel),
    .s3_ready_i (s3_ready)
  );

  lgcb_out_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s3_valid_i (s3_valid),
    .s3_ctl_i   (s3_ctl),
    .s3_res_i   (s3_res),
    .s3_pixel_i (s3_pixel),
    .s3_ready_o (s3_ready),
    .pix_out    (pix_out)
  );

  // A pixel that releases nothing must never occupy the pipeline.
  a_no_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid |-> (s1_ctl.has_up || s1_ctl.emit_own))
    else $error("pipeline holds a pixel with no result");

  // After the last beat of a frame, the next beat starts at column zero.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_out.valid && pix_out.ready && pix_out.frame_end
      |=> !pix_out.valid || (pix_out.out_column == '0))
    else $error("frame did not restart at column zero");

  // Input stalls only behind a pixel held in the first stage.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_in.ready |-> s1_valid)
    else $error("input stalled with an empty first stage");

endmodule

// ----- src/lgcb_line_mem.sv -----
// One line store: synchronous RAM, one write port and two registered read ports.
module lgcb_line_mem import lgcb_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [PIX_W-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr0_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr1_i,
  output logic [PIX_W-1:0]           rdata0_o,
  output logic [PIX_W-1:0]           rdata1_o
);

  logic [PIX_W-1:0] mem [DEPTH];

  // Read first: a read of the entry written at the same edge returns the old word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

// ----- src/lgcb_raster_ctrl.sv -----
// Configuration registers, raster position counters and the first pipeline stage.
module lgcb_raster_ctrl import lgcb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  lgcb_in_if.sink                       pix_in,
  input  logic                          s1_ready_i,
  output logic                          mem_re_o,
  output logic                          mem_sel_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  mem_col_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  mem_col_nxt_o,
  output logic                          s1_valid_o,
  output pix_ctl_t                      s1_ctl_o,
  output logic [PIX_W-1:0]              s1_pixel_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int RW1 = RW + 1;
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HTW = $clog2(MAX_HEIGHT + 1);
  localparam logic [WDW-1:0] WD_RST =
    (FW_RESET > MAX_WIDTH) ? WDW'(MAX_WIDTH) : WDW'(FW_RESET);
  localparam logic [HTW-1:0] HT_RST =
    (FH_RESET > MAX_HEIGHT) ? HTW'(MAX_HEIGHT) : HTW'(FH_RESET);

  logic           aa_en_q;
  logic [WDW-1:0] wd_q, wd_cfg;
  logic [HTW-1:0] ht_q, ht_cfg;
  logic [FW_W-1:0] fw_raw;
  logic [FH_W-1:0] fh_raw;

  logic [CW-1:0]  col_cnt_q, col_cnt_d;
  logic [RW-1:0]  row_cnt_q, row_cnt_d;
  logic           sel_q, sel_d;

  logic           wrap_col;
  logic [CW-1:0]  col;
  logic [RW1-1:0] row_adj;
  logic [RW-1:0]  row;
  logic [WDW-1:0] col_n;
  logic [RW1-1:0] row_n;
  logic           last_col, last_row, has_up, interior;
  logic           ready1, accept;
  logic           s1_valid_q;
  pix_ctl_t       s1_ctl_q;
  logic [PIX_W-1:0] s1_pixel_q;

  // Clamp the written size into 1 .. MAX.
  always_comb begin
    fw_raw = cfg_data_i[FW_W-1:0];
    fh_raw = cfg_data_i[FH_W-1:0];
    if (fw_raw == '0) begin
      wd_cfg = WDW'(1);
    end else if (int'(fw_raw) > MAX_WIDTH) begin
      wd_cfg = WDW'(MAX_WIDTH);
    end else begin
      wd_cfg = WDW'(fw_raw);
    end
    if (fh_raw == '0) begin
      ht_cfg = HTW'(1);
    end else if (int'(fh_raw) > MAX_HEIGHT) begin
      ht_cfg = HTW'(MAX_HEIGHT);
    end else begin
      ht_cfg = HTW'(fh_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aa_en_q <= 1'b1;
      wd_q    <= WD_RST;
      ht_q    <= HT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AA_ENABLE:    aa_en_q <= cfg_data_i[0];
        CFG_FRAME_WIDTH:  wd_q    <= wd_cfg;
        CFG_FRAME_HEIGHT: ht_q    <= ht_cfg;
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel, with the wrap for a size that shrank.
  always_comb begin
    wrap_col = WDW'(col_cnt_q) >= wd_q;
    col      = wrap_col ? '0 : col_cnt_q;
    row_adj  = RW1'(row_cnt_q) + RW1'(wrap_col);
    row      = (row_adj >= RW1'(ht_q)) ? '0 : row_adj[RW-1:0];
    col_n    = WDW'(col) + WDW'(1);
    row_n    = RW1'(row) + RW1'(1);
    last_col = col_n == wd_q;
    last_row = row_n == RW1'(ht_q);
    has_up   = row != '0;
    interior = aa_en_q && (RW1'(row) >= RW1'(2)) && (col != '0) && !last_col;
  end

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    sel_d     = sel_q;
    if (accept) begin
      if (last_col) begin
        col_cnt_d = '0;
        sel_d     = !sel_q;
        row_cnt_d = last_row ? '0 : row_n[RW-1:0];
      end else begin
        col_cnt_d = col_n[CW-1:0];
        row_cnt_d = row;
      end
    end
  end

  assign ready1       = !s1_valid_q || s1_ready_i;
  assign accept       = pix_in.valid && ready1;
  assign pix_in.ready = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      sel_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      sel_q     <= sel_d;
      // Drop pixels that emit nothing (first row) right here.
      if (ready1) begin
        s1_valid_q <= accept && (has_up || last_row);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q.col       <= OUT_COL_W'(col);
      s1_ctl_q.row       <= OUT_ROW_W'(row);
      s1_ctl_q.sel       <= sel_q;
      s1_ctl_q.has_up    <= has_up;
      s1_ctl_q.interior  <= interior;
      s1_ctl_q.emit_own  <= last_row;
      s1_ctl_q.frame_end <= last_col;
      s1_pixel_q         <= pix_in.pixel_in;
    end
  end

  assign mem_re_o      = accept;
  assign mem_sel_o     = sel_q;
  assign mem_col_o     = col;
  assign mem_col_nxt_o = col_n[CW-1:0];
  assign s1_valid_o    = s1_valid_q;
  assign s1_ctl_o      = s1_ctl_q;
  assign s1_pixel_o    = s1_pixel_q;

endmodule

// ----- src/lgcb_cross_filter.sv -----
// Cross filter datapath: tap select, luma, range detect and divide-by-six blend.
module lgcb_cross_filter import lgcb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s1_valid_i,
  input  pix_ctl_t         s1_ctl_i,
  input  logic [PIX_W-1:0] s1_pixel_i,
  input  logic [PIX_W-1:0] a_rd0_i,
  input  logic [PIX_W-1:0] a_rd1_i,
  input  logic [PIX_W-1:0] b_rd0_i,
  input  logic [PIX_W-1:0] b_rd1_i,
  output logic             s1_ready_o,
  output logic             s3_valid_o,
  output pix_ctl_t         s3_ctl_o,
  output logic [PIX_W-1:0] s3_res_o,
  output logic [PIX_W-1:0] s3_pixel_o,
  input  logic             s3_ready_i
);

  logic [PIX_W-1:0]  tap [NUM_TAPS];
  logic [PIX_W-1:0]  w_q;
  logic [LUMA_W-1:0] luma_d [NUM_TAPS];
  logic [SUM_W-1:0]  sum_d  [NUM_CH];

  logic              v2_q, v3_q, ready2, ready3;
  logic [LUMA_W-1:0] luma2_q [NUM_TAPS];
  logic [SUM_W-1:0]  sum2_q  [NUM_CH];
  logic [PIX_W-1:0]  m2_q, pix2_q, m3_q, pix3_q;
  pix_ctl_t          ctl2_q, ctl3_q;

  logic [LUMA_W-1:0] lmax_d, lmin_d, lmax3_q, lmin3_q;
  logic [PROD_W-1:0] prod [NUM_CH];
  logic [CH_W-1:0]   q_d  [NUM_CH];
  logic [CH_W-1:0]   q3_q [NUM_CH];
  logic              edge_hit;

  // Taps: centre, north, south, west, east. West is the previous centre of this row.
  always_comb begin
    tap[0] = s1_ctl_i.sel ? b_rd0_i : a_rd0_i;
    tap[1] = s1_ctl_i.sel ? a_rd0_i : b_rd0_i;
    tap[2] = s1_pixel_i;
    tap[3] = w_q;
    tap[4] = s1_ctl_i.sel ? b_rd1_i : a_rd1_i;
    for (int k = 0; k < NUM_TAPS; k++) begin
      luma_d[k] = luma1000(tap[k]);
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_d[ch] = (SUM_W'(tap[0][CH_W*ch +: CH_W]) << 1)
                + SUM_W'(tap[1][CH_W*ch +: CH_W]) + SUM_W'(tap[2][CH_W*ch +: CH_W])
                + SUM_W'(tap[3][CH_W*ch +: CH_W]) + SUM_W'(tap[4][CH_W*ch +: CH_W]);
    end
  end

  always_comb begin
    lmax_d = luma2_q[0];
    lmin_d = luma2_q[0];
    for (int k = 1; k < NUM_TAPS; k++) begin
      if (luma2_q[k] > lmax_d) lmax_d = luma2_q[k];
      if (luma2_q[k] < lmin_d) lmin_d = luma2_q[k];
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = PROD_W'(sum2_q[ch]) * PROD_W'(RECIP6);
      q_d[ch]  = prod[ch][RECIP_SHIFT +: CH_W];
    end
  end

  assign ready3     = !v3_q || s3_ready_i;
  assign ready2     = !v2_q || ready3;
  assign s1_ready_o = ready2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready2) v2_q <= s1_valid_i;
      if (ready3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && ready2) begin
      luma2_q <= luma_d;
      sum2_q  <= sum_d;
      m2_q    <= tap[0];
      pix2_q  <= s1_pixel_i;
      ctl2_q  <= s1_ctl_i;
      w_q     <= tap[0];
    end
    if (v2_q && ready3) begin
      lmax3_q <= lmax_d;
      lmin3_q <= lmin_d;
      q3_q    <= q_d;
      m3_q    <= m2_q;
      pix3_q  <= pix2_q;
      ctl3_q  <= ctl2_q;
    end
  end

  // Blend only interior pixels on a strong luma edge; alpha stays from the centre.
  assign edge_hit   = (lmax3_q - lmin3_q) >= LUMA_THRESH;
  assign s3_res_o   = (ctl3_q.interior && edge_hit) ? {m3_q[PIX_W-1:CH_W*NUM_CH], q3_q[2],
                                                       q3_q[1], q3_q[0]} : m3_q;
  assign s3_valid_o = v3_q;
  assign s3_ctl_o   = ctl3_q;
  assign s3_pixel_o = pix3_q;

endmodule

// ----- src/lgcb_out_emit.sv -----
// Result sequencer: sends the upper-row pixel and, in the last row, the own pixel.
module lgcb_out_emit import lgcb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s3_valid_i,
  input  pix_ctl_t         s3_ctl_i,
  input  logic [PIX_W-1:0] s3_res_i,
  input  logic [PIX_W-1:0] s3_pixel_i,
  output logic             s3_ready_o,
  lgcb_out_if.source       pix_out
);

  logic             v4_q, pend_up_q, pend_own_q;
  pix_ctl_t         ctl4_q;
  logic [PIX_W-1:0] res4_q, pix4_q;
  logic             out_valid_q, out_free, last_beat, leave4, ready4;

  assign out_free  = !out_valid_q || pix_out.ready;
  assign last_beat = !(pend_up_q && pend_own_q);
  assign leave4    = v4_q && out_free && last_beat;
  assign ready4    = !v4_q || leave4;
  assign s3_ready_o = ready4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q        <= 1'b0;
      pend_up_q   <= 1'b0;
      pend_own_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready4) begin
        v4_q <= s3_valid_i;
        if (s3_valid_i) begin
          pend_up_q  <= s3_ctl_i.has_up;
          pend_own_q <= s3_ctl_i.emit_own;
        end
      end else if (v4_q && out_free) begin
        // Upper-row beat goes out first; hold the own pixel for the next beat.
        pend_up_q <= 1'b0;
      end
      if (out_free) out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_i && ready4) begin
      ctl4_q <= s3_ctl_i;
      res4_q <= s3_res_i;
      pix4_q <= s3_pixel_i;
    end
    if (out_free && v4_q) begin
      pix_out.out_column <= ctl4_q.col;
      if (pend_up_q) begin
        pix_out.pixel_out <= res4_q;
        pix_out.out_row   <= ctl4_q.row - OUT_ROW_W'(1);
        pix_out.frame_end <= 1'b0;
      end else begin
        pix_out.pixel_out <= pix4_q;
        pix_out.out_row   <= ctl4_q.row;
        pix_out.frame_end <= ctl4_q.frame_end;
      end
    end
  end

  assign pix_out.valid = out_valid_q;

endmodule

// ----- tb/sv/lgcb_blend_checker.sv -----
// Scoreboard for the cross blend filter: mirrors the line stores, predicts and checks output beats.
module lgcb_blend_checker import lgcb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lgcb_in_if                    pix_in,
  lgcb_out_if                   pix_out,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           pixels_in_o,
  output int unsigned           pixels_out_o,
  output int unsigned           blended_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EDGE_LUMA_STEP = 12000;
  localparam int          CROSS_TAPS     = 5;

  typedef struct packed {
    logic [PIX_W-1:0]     pixel;
    logic [OUT_COL_W-1:0] column;
    logic [OUT_ROW_W-1:0] row;
    logic                 last;
  } out_beat_t;

  logic [PIX_W-1:0] line_a [MAX_WIDTH];
  logic [PIX_W-1:0] line_b [MAX_WIDTH];
  logic             newest_is_b = 1'b0;
  int unsigned      next_col    = 0;
  int unsigned      next_row    = 0;

  logic             aa_on      = 1'b1;
  logic [FW_W-1:0]  width_reg  = FW_W'(FW_RESET);
  logic [FH_W-1:0]  height_reg = FH_W'(FH_RESET);

  out_beat_t        expected_q [$];
  int unsigned      fails   = 0;
  int unsigned      n_in    = 0;
  int unsigned      n_out   = 0;
  int unsigned      n_blend = 0;

  function automatic int unsigned luma_x1000(input logic [PIX_W-1:0] p);
    return 299 * p[7:0] + 587 * p[15:8] + 114 * p[23:16];
  endfunction

  function automatic logic [PIX_W-1:0] newest_at(input int unsigned idx);
    return newest_is_b ? line_b[idx] : line_a[idx];
  endfunction

  task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                             input logic [PIX_W-1:0] got);
    if (got !== want) begin
      fails++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Take one input pixel, update the mirrored stores and queue the pixels it releases.
  task automatic filter_pixel(input logic [PIX_W-1:0] pix);
    int unsigned      wd;
    int unsigned      ht;
    int unsigned      col;
    int unsigned      row;
    int unsigned      hi;
    int unsigned      lo;
    int unsigned      lum;
    int unsigned      sum;
    logic [PIX_W-1:0] north;
    logic [PIX_W-1:0] res;
    logic [PIX_W-1:0] taps [CROSS_TAPS];
    out_beat_t        beat;
    wd = (width_reg == 0) ? 1 : width_reg;
    if (wd > MAX_WIDTH) wd = MAX_WIDTH;
    ht = (height_reg == 0) ? 1 : height_reg;
    if (ht > MAX_HEIGHT) ht = MAX_HEIGHT;

    if (next_col >= wd) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= ht) next_row = 0;
    col = next_col;
    row = next_row;

    // Read-first: the older row gives the north tap before the new pixel lands.
    if (newest_is_b) begin
      north      = line_a[col];
      line_a[col] = pix;
    end else begin
      north      = line_b[col];
      line_b[col] = pix;
    end

    if (row >= 1) begin
      res = newest_at(col);
      if (aa_on && row >= 2 && col >= 1 && col + 1 < wd) begin
        taps[0] = res;
        taps[1] = north;
        taps[2] = pix;
        taps[3] = newest_at(col - 1);
        taps[4] = newest_at(col + 1);
        hi = 0;
        lo = '1;
        for (int t = 0; t < CROSS_TAPS; t++) begin
          lum = luma_x1000(taps[t]);
          if (lum > hi) hi = lum;
          if (lum < lo) lo = lum;
        end
        if (hi - lo >= EDGE_LUMA_STEP) begin
          for (int k = 0; k < 3; k++) begin
            sum = 2 * taps[0][8*k +: 8] + taps[1][8*k +: 8] + taps[2][8*k +: 8]
                + taps[3][8*k +: 8] + taps[4][8*k +: 8];
            res[8*k +: 8] = 8'(sum / 6);
          end
          n_blend++;
        end
      end
      beat.pixel  = res;
      beat.column = OUT_COL_W'(col);
      beat.row    = OUT_ROW_W'(row - 1);
      beat.last   = 1'b0;
      expected_q.push_back(beat);
    end

    if (row + 1 == ht) begin
      beat.pixel  = pix;
      beat.column = OUT_COL_W'(col);
      beat.row    = OUT_ROW_W'(row);
      beat.last   = (col + 1 == wd);
      expected_q.push_back(beat);
    end

    next_col = col + 1;
    if (next_col >= wd) begin
      next_col    = 0;
      newest_is_b = !newest_is_b;
      next_row    = row + 1;
      if (next_row >= ht) next_row = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      newest_is_b = 1'b0;
      next_col    = 0;
      next_row    = 0;
      aa_on       = 1'b1;
      width_reg   = FW_W'(FW_RESET);
      height_reg  = FH_W'(FH_RESET);
      expected_q.delete();
    end else begin
      // Compare first so a beat arriving with a new input cannot match its own prediction.
      if (pix_out.valid && pix_out.ready) begin
        n_out++;
        if (expected_q.size() == 0) begin
          fails++;
          $error("output beat with nothing expected: pixel_out 0x%0h, column %0d, row %0d",
                 pix_out.pixel_out, pix_out.out_column, pix_out.out_row);
        end else begin
          want = expected_q.pop_front();
          check_field("pixel_out", want.pixel, pix_out.pixel_out);
          check_field("out_column", PIX_W'(want.column), PIX_W'(pix_out.out_column));
          check_field("out_row", PIX_W'(want.row), PIX_W'(pix_out.out_row));
          check_field("frame_end", PIX_W'(want.last), PIX_W'(pix_out.frame_end));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_AA_ENABLE:    aa_on      = cfg_data_i[0];
          CFG_FRAME_WIDTH:  width_reg  = cfg_data_i[FW_W-1:0];
          CFG_FRAME_HEIGHT: height_reg = cfg_data_i[FH_W-1:0];
          default: ;
        endcase
      end
      if (pix_in.valid && pix_in.ready) begin
        n_in++;
        filter_pixel(pix_in.pixel_in);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    pixels_in_o  <= n_in;
    pixels_out_o <= n_out;
    blended_o    <= n_blend;
  end

endmodule

// ----- tb/sv/luma_gated_cross_blend_antialias_tb.sv -----
// Testbench top for the cross blend filter: clock, reset, stimulus, flow control and verdict.
module luma_gated_cross_blend_antialias_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgcb_pkg::*;

  // Flow-control regimes, rotated per register setting.
  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_e;

  localparam int unsigned HEAVY_PCT     = 62;
  localparam int unsigned LIGHT_PCT     = 17;
  localparam int unsigned RANDOM_PIXELS = 700;
  // Clocks to wait after the last expected result; leave generous slack.
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned RUN_LIMIT_NS  = 8_000_000;

  // Directed 3x3 frames: R=14 gives luma 4186; G=20,B=39 gives 16186, exactly 12000 above.
  // With B=38 the north tap sits at 16072, just under the edge threshold.
  localparam logic [PIX_W-1:0] LOW_LUMA_PIX  = 32'hFF00_000E;
  localparam logic [PIX_W-1:0] EDGE_PIX      = 32'h0027_1400;
  localparam logic [PIX_W-1:0] NEAR_EDGE_PIX = 32'h0026_1400;
  localparam logic [PIX_W-1:0] CROSS_TEMPLATE [9] = '{
    32'hFFFF_FFFF, EDGE_PIX,     32'h0000_0000,
    LOW_LUMA_PIX,  LOW_LUMA_PIX, LOW_LUMA_PIX,
    32'h0000_0000, LOW_LUMA_PIX, 32'hFFFF_FFFF
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lgcb_in_if  pix_in ();
  lgcb_out_if pix_out ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned pixels_in;
  int unsigned pixels_out;
  int unsigned blended;

  flow_e       flow       = FLOW_FREE;
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned n_sent     = 0;
  int unsigned n_settings = 0;

  luma_gated_cross_blend_antialias dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_in     (pix_in),
    .pix_out    (pix_out)
  );

  lgcb_blend_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pix_in       (pix_in),
    .pix_out      (pix_out),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .pixels_in_o  (pixels_in),
    .pixels_out_o (pixels_out),
    .blended_o    (blended)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sink side: drop ready at random according to the current regime.
  initial begin
    pix_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      pix_out.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Hold valid high across back-to-back beats; drop it only when a gap is rolled, so the
  // line never sees two nonblocking writes in one step.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if ($urandom_range(99) < gap_pct) begin
      pix_in.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    pix_in.valid    <= 1'b1;
    pix_in.pixel_in <= pix;
    do @(posedge clk_i); while (!pix_in.ready);
    n_sent++;
  endtask

  // Drop valid, wait for every expected beat, then let the pipeline go quiet.
  task automatic settle();
    pix_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
  endtask

  // One full frame of raster pixels. Mix smooth patches (no blend), single-channel edges,
  // saturated extremes and pure noise around a per-frame base color.
  task automatic send_frame(input int unsigned wd, input int unsigned ht);
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] pix;
    int unsigned      pick;
    int unsigned      lane;
    base = $urandom;
    repeat (wd * ht) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        pix = base ^ ($urandom & 32'hFF03_0303);
      end else if (pick < 75) begin
        pix = base;
        lane = $urandom_range(2);
        pix[8*lane +: 8] = 8'($urandom);
        pix[31:24] = 8'($urandom);
      end else if (pick < 85) begin
        pix = $urandom_range(1) ? '1 : '0;
      end else begin
        pix = $urandom;
      end
      send_pixel(pix);
    end
  endtask

  // Quiesce, program all three registers, pick the next flow regime and stream frames.
  task automatic run_setting(input logic en, input int unsigned wd, input int unsigned ht,
                             input int unsigned frames);
    int unsigned eff_w;
    int unsigned eff_h;
    settle();
    write_reg(CFG_AA_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(wd));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(ht));
    cfg_we <= 1'b0;
    eff_w = (wd == 0) ? 1 : ((wd > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : wd);
    eff_h = (ht == 0) ? 1 : ((ht > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : ht);
    flow = flow_e'(n_settings % 4);
    case (flow)
      FLOW_SENDER_GAPS: begin gap_pct = HEAVY_PCT; stall_pct = 0;         end
      FLOW_SINK_STALLS: begin gap_pct = 0;         stall_pct = HEAVY_PCT; end
      FLOW_BOTH:        begin gap_pct = LIGHT_PCT; stall_pct = LIGHT_PCT; end
      default:          begin gap_pct = 0;         stall_pct = 0;         end
    endcase
    n_settings++;
    repeat (frames) send_frame(eff_w, eff_h);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned pick;
    int unsigned wd;
    int unsigned ht;
    logic        en;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    pix_in.valid    = 1'b0;
    pix_in.pixel_in = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: one interior pixel whose luma spread sits exactly on the threshold (blends),
    // then the same frame with the north tap just under it (passes).
    run_setting(1'b1, 3, 3, 0);
    for (int f = 0; f < 2; f++) begin
      for (int i = 0; i < 9; i++) begin
        send_pixel((i == 1) ? ((f == 0) ? EDGE_PIX : NEAR_EDGE_PIX) : CROSS_TEMPLATE[i]);
      end
    end

    run_setting(1'b0, 5, 4, 2);       // blend off, same one-row lag
    run_setting(1'b1, 1, 5, 2);       // single column: all border
    run_setting(1'b1, 6, 1, 2);       // single row: each pixel releases only itself
    run_setting(1'b1, 0, 0, 3);       // zero sizes act as 1x1
    run_setting(1'b1, 2, 2, 2);       // smallest frame with a full lag row
    run_setting(1'b1, 2047, 1, 1);    // oversized width clamps to the line store depth

    // Random settings: mostly small frames so many frame boundaries and edges are seen.
    random_start = n_sent;
    while (n_sent - random_start < RANDOM_PIXELS) begin
      en = ($urandom_range(99) < 85);
      pick = $urandom_range(99);
      if (pick < 70)      wd = $urandom_range(2, 10);
      else if (pick < 88) wd = $urandom_range(11, 48);
      else                wd = $urandom_range(1);
      pick = $urandom_range(99);
      if (pick < 75)      ht = $urandom_range(2, 6);
      else if (pick < 90) ht = $urandom_range(7, 16);
      else                ht = $urandom_range(1);
      run_setting(en, wd, ht, $urandom_range(1, 3));
    end
    settle();

    $display("Streamed %0d pixels in and %0d out over %0d register settings", pixels_in,
             pixels_out, n_settings);
    $display("Blend on and off, sizes from 0 to oversized, %0d pixels took the edge blend",
             blended);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS luma_gated_cross_blend_antialias");
    end else begin
      $display("FAIL luma_gated_cross_blend_antialias");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    #(RUN_LIMIT_NS);
    $error("run limit reached with %0d results outstanding", pending);
    $display("FAIL luma_gated_cross_blend_antialias");
    $finish;
  end

endmodule
